// ===== rtl/bgb_pkg.sv =====
// Shared types, constants and helper functions of the bitmap glyph blitter.
// Depends on nothing; every other file of the block but bgb_ram refers to it by scoped names.
package bgb_pkg;

	localparam int MAX_GLYPH_SIDE_DEF = 8;
	localparam int FONT_CHARS_DEF     = 256;

	localparam int STORE_DEPTH = 2048;
	localparam int STORE_AW    = 11;
	localparam int FONT_BYTE_W = 8;
	localparam int CODE_W      = 8;
	localparam int TEXT_W      = 10;
	localparam int COLOR_W     = 32;
	localparam int ADDR_W      = 32;
	localparam int PITCH_W     = 16;
	localparam int BPP_W       = 3;
	localparam int SIDE_CFG_W  = 4;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_BASE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT    = 3'd4;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	// Leftmost pixel of a glyph row sits in the most significant font bit.
	localparam int GLYPH_MSB = 7;

	localparam logic [BPP_W-1:0] BPP_MIN = 3'd1;
	localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0]     frame_base;
		logic [PITCH_W-1:0]    line_pitch;
		logic [BPP_W-1:0]      bytes_per_pixel;
		logic [SIDE_CFG_W-1:0] glyph_width;
		logic [SIDE_CFG_W-1:0] glyph_height;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic mul1;
		logic mul2;
		logic sum;
		logic fetch;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_mode;
		logic draw_empty;
		logic out_free;
		logic row_end;
		logic glyph_end;
	} status_t;

	function automatic logic [BPP_W-1:0] bpp_sat(input logic [BPP_W-1:0] v);
		logic [BPP_W-1:0] r;
		priority if (v == '0) begin
			r = BPP_MIN;
		end else if (v > BPP_MAX) begin
			r = BPP_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] value_mask(input logic [BPP_W-1:0] bpp);
		logic [COLOR_W-1:0] m;
		unique case (bpp)
			3'd1:    m = 32'h0000_00FF;
			3'd2:    m = 32'h0000_FFFF;
			3'd3:    m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/bgb_if.sv =====
// Valid/ready channel interfaces of the glyph blitter: request items in, pixel writes out.
// Depends on bgb_pkg for the field widths.
interface bgb_glyph_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [bgb_pkg::STORE_AW-1:0]   font_index;
	logic [bgb_pkg::FONT_BYTE_W-1:0] font_byte;
	logic [bgb_pkg::CODE_W-1:0]     char_code;
	logic [bgb_pkg::TEXT_W-1:0]     text_column;
	logic [bgb_pkg::TEXT_W-1:0]     text_row;
	logic [bgb_pkg::COLOR_W-1:0]    fg_color;
	logic [bgb_pkg::COLOR_W-1:0]    bg_color;

	modport source (
		output valid, mode, font_index, font_byte, char_code, text_column, text_row,
		       fg_color, bg_color,
		input  ready
	);
	modport sink (
		input  valid, mode, font_index, font_byte, char_code, text_column, text_row,
		       fg_color, bg_color,
		output ready
	);
endinterface

interface bgb_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [bgb_pkg::ADDR_W-1:0]  pixel_address;
	logic [bgb_pkg::COLOR_W-1:0] pixel_value;
	logic                        last_pixel;

	modport source (output valid, pixel_address, pixel_value, last_pixel, input ready);
	modport sink (input valid, pixel_address, pixel_value, last_pixel, output ready);
endinterface

// ===== rtl/bitmap_glyph_blitter.sv =====
// Top level of the bitmap glyph blitter: configuration registers, sequencer and datapath.
// Depends on bgb_pkg, bgb_if, bgb_regs, bgb_ctrl, bgb_dp and bgb_ram.
//
// The block keeps a 2048-byte font store and turns character draw requests into framebuffer
// pixel writes. A request with mode 0 loads one font byte at font_index and produces no
// output. A request with mode 1 draws char_code at text cell (text_column, text_row): it
// produces width*height pixel write transfers in row-major order, leftmost pixel first,
// with last_pixel set on the final one. Each write carries frame_base + row*height*pitch +
// column*width*bpp + py*pitch + px*bpp (modulo 2^32) and the foreground colour where the
// font bit is set, else the background colour, masked to bytes_per_pixel bytes. Glyph
// sides saturate at MAX_GLYPH_SIDE, bytes per pixel is held to 1..4, codes wrap modulo
// FONT_CHARS, and a zero width or height draws nothing. Font entries are not cleared at
// reset: load every glyph row before drawing it. A draw request is taken only while the
// block is idle and occupies it until its last pixel is emitted: address setup through
// the offset multipliers (states MUL1, MUL2 and SUM), then for every glyph row the font
// store's registered read (state FETCH) followed by one pixel per cycle while the pixel
// sink does not stall. Pixel writes leave through an output register, so the last pixel
// of a glyph may still wait while the next request is taken. Configuration registers sit
// at byte address 4*index and must be written only while no draw is in progress.
module bitmap_glyph_blitter #(
	parameter int MAX_GLYPH_SIDE = bgb_pkg::MAX_GLYPH_SIDE_DEF,
	parameter int FONT_CHARS     = bgb_pkg::FONT_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgb_pkg::APB_AW-1:0]  paddr,
	input  logic [bgb_pkg::APB_DW-1:0]  pwdata,
	output logic [bgb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	bgb_glyph_if.sink                   glyph_req,
	bgb_pixel_if.source                 pixel_wr
);

	bgb_pkg::cfg_t    cfg;
	bgb_pkg::cmd_t    cmd;
	bgb_pkg::status_t status;
	logic             in_ready;

	bgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer owns the request handshake; a request transfers only in its idle state.
	bgb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	assign glyph_req.ready = in_ready;

	bgb_dp #(
		.MAX_GLYPH_SIDE (MAX_GLYPH_SIDE),
		.FONT_CHARS     (FONT_CHARS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.in_valid          (glyph_req.valid),
		.in_mode           (glyph_req.mode),
		.in_font_index     (glyph_req.font_index),
		.in_font_byte      (glyph_req.font_byte),
		.in_char_code      (glyph_req.char_code),
		.in_text_column    (glyph_req.text_column),
		.in_text_row       (glyph_req.text_row),
		.in_fg_color       (glyph_req.fg_color),
		.in_bg_color       (glyph_req.bg_color),
		.out_valid         (pixel_wr.valid),
		.out_ready         (pixel_wr.ready),
		.out_pixel_address (pixel_wr.pixel_address),
		.out_pixel_value   (pixel_wr.pixel_value),
		.out_last_pixel    (pixel_wr.last_pixel)
	);

endmodule

// ===== rtl/bgb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bgb_regs.sv =====
// APB-style configuration register file of the glyph blitter.
// Depends on bgb_pkg for the register layout and the cfg_t bundle.
module bgb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgb_pkg::APB_AW-1:0]  paddr,
	input  logic [bgb_pkg::APB_DW-1:0]  pwdata,
	output logic [bgb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output bgb_pkg::cfg_t               cfg
);

	bgb_pkg::cfg_t                    cfg_q;
	logic [bgb_pkg::REG_IDX_W-1:0]    idx;
	logic                             wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[bgb_pkg::APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base      <= '0;
			cfg_q.line_pitch      <= 16'd4096;
			cfg_q.bytes_per_pixel <= 3'd4;
			cfg_q.glyph_width     <= 4'd8;
			cfg_q.glyph_height    <= 4'd8;
		end else if (wr_en) begin
			unique case (idx)
				bgb_pkg::REG_FRAME_BASE:      cfg_q.frame_base <= pwdata;
				bgb_pkg::REG_LINE_PITCH:
					cfg_q.line_pitch <= pwdata[bgb_pkg::PITCH_W-1:0];
				bgb_pkg::REG_BYTES_PER_PIXEL:
					cfg_q.bytes_per_pixel <= pwdata[bgb_pkg::BPP_W-1:0];
				bgb_pkg::REG_GLYPH_WIDTH:
					cfg_q.glyph_width <= pwdata[bgb_pkg::SIDE_CFG_W-1:0];
				bgb_pkg::REG_GLYPH_HEIGHT:
					cfg_q.glyph_height <= pwdata[bgb_pkg::SIDE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bgb_pkg::REG_FRAME_BASE:      prdata = cfg_q.frame_base;
			bgb_pkg::REG_LINE_PITCH:      prdata = bgb_pkg::APB_DW'(cfg_q.line_pitch);
			bgb_pkg::REG_BYTES_PER_PIXEL: prdata = bgb_pkg::APB_DW'(cfg_q.bytes_per_pixel);
			bgb_pkg::REG_GLYPH_WIDTH:     prdata = bgb_pkg::APB_DW'(cfg_q.glyph_width);
			bgb_pkg::REG_GLYPH_HEIGHT:    prdata = bgb_pkg::APB_DW'(cfg_q.glyph_height);
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/bgb_ctrl.sv =====
// Sequencer of the glyph blitter: steps the datapath through setup, row fetch and pixels.
// Depends on bgb_pkg for the command and status bundles.
module bgb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  bgb_pkg::status_t   status,
	output bgb_pkg::cmd_t      cmd,
	output logic               in_ready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_FETCH,
		ST_PIXEL
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load    = status.in_valid && (status.in_mode == bgb_pkg::MODE_LOAD);
				cmd.capture = status.in_valid && (status.in_mode == bgb_pkg::MODE_DRAW) &&
				              !status.draw_empty;
			end
			ST_MUL1:  cmd.mul1  = 1'b1;
			ST_MUL2:  cmd.mul2  = 1'b1;
			ST_SUM:   cmd.sum   = 1'b1;
			ST_FETCH: cmd.fetch = 1'b1;
			ST_PIXEL: cmd.emit  = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_PIXEL;
				ST_PIXEL: begin
					if (status.out_free && status.row_end) begin
						state_q <= status.glyph_end ? ST_IDLE : ST_FETCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/bgb_dp.sv =====
// Datapath of the glyph blitter: address arithmetic, font store, pixel counters and the
// output register. Depends on bgb_pkg and bgb_ram.
module bgb_dp #(
	parameter int MAX_GLYPH_SIDE = bgb_pkg::MAX_GLYPH_SIDE_DEF,
	parameter int FONT_CHARS     = bgb_pkg::FONT_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bgb_pkg::cfg_t                    cfg,
	input  bgb_pkg::cmd_t                    cmd,
	output bgb_pkg::status_t                 status,
	input  logic                             in_valid,
	input  logic                             in_mode,
	input  logic [bgb_pkg::STORE_AW-1:0]     in_font_index,
	input  logic [bgb_pkg::FONT_BYTE_W-1:0]  in_font_byte,
	input  logic [bgb_pkg::CODE_W-1:0]       in_char_code,
	input  logic [bgb_pkg::TEXT_W-1:0]       in_text_column,
	input  logic [bgb_pkg::TEXT_W-1:0]       in_text_row,
	input  logic [bgb_pkg::COLOR_W-1:0]      in_fg_color,
	input  logic [bgb_pkg::COLOR_W-1:0]      in_bg_color,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bgb_pkg::ADDR_W-1:0]       out_pixel_address,
	output logic [bgb_pkg::COLOR_W-1:0]      out_pixel_value,
	output logic                             out_last_pixel
);

	localparam int CNT_W = $clog2(MAX_GLYPH_SIDE + 1);
	localparam int IDX_W = (MAX_GLYPH_SIDE > 1) ? $clog2(MAX_GLYPH_SIDE) : 1;
	localparam int RH_W  = bgb_pkg::TEXT_W + CNT_W;
	localparam int CH_W  = bgb_pkg::CODE_W + CNT_W;
	localparam int RHP_W = RH_W + bgb_pkg::PITCH_W;
	localparam int CWB_W = RH_W + bgb_pkg::BPP_W;
	localparam int AW    = bgb_pkg::ADDR_W;

	logic [CNT_W-1:0]                w_eff, h_eff;
	logic [bgb_pkg::BPP_W-1:0]       bpp_eff;
	logic [bgb_pkg::CODE_W-1:0]      code_eff;

	logic [bgb_pkg::CODE_W-1:0]      code_q;
	logic [bgb_pkg::TEXT_W-1:0]      col_q, row_q;
	logic [bgb_pkg::COLOR_W-1:0]     fg_q, bg_q;
	logic [RH_W-1:0]                 rh_q, cw_q;
	logic [CH_W-1:0]                 ch_q;
	logic [RHP_W-1:0]                rhp_q;
	logic [CWB_W-1:0]                cwb_q;
	logic [AW-1:0]                   line_q, addr_q;
	logic [IDX_W-1:0]                px_q, py_q;

	logic                            out_valid_q, out_last_q;
	logic [AW-1:0]                   out_addr_q;
	logic [bgb_pkg::COLOR_W-1:0]     out_value_q;

	logic [CH_W:0]                   font_sum;
	logic [bgb_pkg::STORE_AW-1:0]    font_raddr;
	logic [bgb_pkg::FONT_BYTE_W-1:0] row_bits;
	logic [2:0]                      bit_idx;
	logic                            pix_on;
	logic                            row_end, glyph_end;

	// Saturate the glyph sides and the pixel size, and wrap the character code.
	assign w_eff = (cfg.glyph_width > bgb_pkg::SIDE_CFG_W'(MAX_GLYPH_SIDE)) ?
	               CNT_W'(MAX_GLYPH_SIDE) : CNT_W'(cfg.glyph_width);
	assign h_eff = (cfg.glyph_height > bgb_pkg::SIDE_CFG_W'(MAX_GLYPH_SIDE)) ?
	               CNT_W'(MAX_GLYPH_SIDE) : CNT_W'(cfg.glyph_height);
	assign bpp_eff = bgb_pkg::bpp_sat(cfg.bytes_per_pixel);
	assign code_eff = ({1'b0, in_char_code} >= (bgb_pkg::CODE_W + 1)'(FONT_CHARS)) ?
	                  in_char_code - bgb_pkg::CODE_W'(FONT_CHARS) : in_char_code;

	assign font_sum   = (CH_W + 1)'(ch_q) + (CH_W + 1)'(py_q);
	assign font_raddr = bgb_pkg::STORE_AW'(font_sum);

	bgb_ram #(
		.WIDTH (bgb_pkg::FONT_BYTE_W),
		.DEPTH (bgb_pkg::STORE_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (in_font_index),
		.wdata (in_font_byte),
		.raddr (font_raddr),
		.rdata (row_bits)
	);

	assign bit_idx   = 3'(bgb_pkg::GLYPH_MSB) - 3'(px_q);
	assign pix_on    = row_bits[bit_idx];
	assign row_end   = (CNT_W'(px_q) + CNT_W'(1)) == w_eff;
	assign glyph_end = (CNT_W'(py_q) + CNT_W'(1)) == h_eff;

	assign status.in_valid   = in_valid;
	assign status.in_mode    = in_mode;
	assign status.draw_empty = (w_eff == '0) || (h_eff == '0);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.row_end    = row_end;
	assign status.glyph_end  = glyph_end;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= code_eff;
			col_q  <= in_text_column;
			row_q  <= in_text_row;
			fg_q   <= in_fg_color;
			bg_q   <= in_bg_color;
		end
		if (cmd.mul1) begin
			rh_q <= RH_W'(row_q) * RH_W'(h_eff);
			cw_q <= RH_W'(col_q) * RH_W'(w_eff);
			ch_q <= CH_W'(code_q) * CH_W'(h_eff);
		end
		if (cmd.mul2) begin
			rhp_q <= RHP_W'(rh_q) * RHP_W'(cfg.line_pitch);
			cwb_q <= CWB_W'(cw_q) * CWB_W'(bpp_eff);
		end
		if (cmd.sum) begin
			line_q <= cfg.frame_base + AW'(rhp_q) + AW'(cwb_q);
		end else if (cmd.emit && row_end) begin
			line_q <= line_q + AW'(cfg.line_pitch);
		end
		if (cmd.fetch) begin
			addr_q <= line_q;
		end else if (cmd.emit) begin
			addr_q <= addr_q + AW'(bpp_eff);
		end
		if (cmd.emit) begin
			out_addr_q  <= addr_q;
			out_value_q <= (pix_on ? fg_q : bg_q) & bgb_pkg::value_mask(bpp_eff);
			out_last_q  <= row_end && glyph_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q        <= '0;
			py_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				px_q <= '0;
				py_q <= '0;
			end else if (cmd.emit) begin
				if (row_end) begin
					px_q <= '0;
					py_q <= py_q + IDX_W'(1);
				end else begin
					px_q <= px_q + IDX_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_pixel_address = out_addr_q;
	assign out_pixel_value   = out_value_q;
	assign out_last_pixel    = out_last_q;

	// A new pixel never overwrites one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("pixel emitted while the output register was still full");

	// The pixel counters stay inside the glyph while pixels go out.
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> ((CNT_W'(px_q) < w_eff) && (CNT_W'(py_q) < h_eff)))
		else $error("pixel counter outside the glyph");

	// The font read address is stable when its row bits are used.
	a_row_read_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> $stable(font_raddr))
		else $error("font row used before its read completed");

endmodule

// ===== sim/bitmap_glyph_blitter_tb.sv =====
// Self-checking testbench of the bitmap glyph blitter: directed and random glyph draws.
// Depends on bgb_pkg, the bgb_if channel interfaces and the bitmap_glyph_blitter RTL.
module bitmap_glyph_blitter_tb;

	// Generous bound on the whole run; a correct run needs a small fraction of it.
	localparam int CYCLE_LIMIT = 1000000;
	// Cycles to let pass after the last expected pixel before touching the registers
	// or ending the run, long enough for a full 8x8 draw and the output register.
	localparam int SETTLE_CYCLES = 120;
	// Request items to send over the whole run, font loads included.
	localparam int ITEM_TARGET = 270;
	// Register settings tried by the random traffic, and how many character codes
	// each of them draws, so that glyph rows loaded once are drawn many times.
	localparam int RANDOM_PHASES = 6;
	localparam int CODE_POOL     = 4;
	localparam int PAUSE_PHASE   = 2;

	// One request item as the testbench builds it.
	typedef struct {
		logic                            mode;
		logic [bgb_pkg::STORE_AW-1:0]    font_index;
		logic [bgb_pkg::FONT_BYTE_W-1:0] font_byte;
		logic [bgb_pkg::CODE_W-1:0]      char_code;
		logic [bgb_pkg::TEXT_W-1:0]      text_column;
		logic [bgb_pkg::TEXT_W-1:0]      text_row;
		logic [bgb_pkg::COLOR_W-1:0]     fg_color;
		logic [bgb_pkg::COLOR_W-1:0]     bg_color;
	} glyph_item_t;

	// One pixel write as the blitter should produce it.
	typedef struct {
		logic [bgb_pkg::ADDR_W-1:0]  pixel_address;
		logic [bgb_pkg::COLOR_W-1:0] pixel_value;
		logic                        last_pixel;
	} pixel_write_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bgb_pkg::APB_AW-1:0] paddr;
	logic [bgb_pkg::APB_DW-1:0] pwdata;
	logic [bgb_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	bgb_glyph_if glyph_req ();
	bgb_pixel_if pixel_wr ();

	bitmap_glyph_blitter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.glyph_req (glyph_req),
		.pixel_wr  (pixel_wr)
	);

	// Shadow of the register file and of the font store, kept in step with every
	// accepted transfer. font_loaded marks the store entries that hold a known byte;
	// no draw is ever sent that would read an entry outside that set.
	bgb_pkg::cfg_t                   cfg_shadow;
	logic [bgb_pkg::FONT_BYTE_W-1:0] font_shadow [bgb_pkg::STORE_DEPTH];
	bit                              font_loaded [bgb_pkg::STORE_DEPTH];

	// Pixel writes still owed by the block, oldest first.
	pixel_write_t pixels_due [$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  items_sent  = 0;
	// When set, the matching side of the handshake runs with no idle cycles at all.
	bit  sender_calm = 1'b0;
	bit  sink_calm   = 1'b0;
	int  sink_hold   = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Everything the testbench drives starts at a known value before the first edge.
	initial begin
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		glyph_req.valid       = 1'b0;
		glyph_req.mode        = bgb_pkg::MODE_LOAD;
		glyph_req.font_index  = '0;
		glyph_req.font_byte   = '0;
		glyph_req.char_code   = '0;
		glyph_req.text_column = '0;
		glyph_req.text_row    = '0;
		glyph_req.fg_color    = '0;
		glyph_req.bg_color    = '0;
		pixel_wr.ready        = 1'b0;
	end

	// Watchdog: a hung handshake or a lost pixel ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Pixel sink pacing. After every transfer the sink draws a random stall (none when
	// sink_calm is set) and drops ready for that long, so stalls can land on any pixel of a glyph.
	always @(posedge clk) begin : sink_pace
		int stall;
		if (!arst_n) begin
			pixel_wr.ready <= 1'b0;
			sink_hold      <= 0;
		end else if (pixel_wr.ready) begin
			if (pixel_wr.valid) begin
				stall = sink_calm ? 0 : $urandom_range(0, 7);
				if (stall > 0) begin
					pixel_wr.ready <= 1'b0;
					sink_hold      <= stall;
				end
			end
		end else if (sink_hold <= 1) begin
			pixel_wr.ready <= 1'b1;
			sink_hold      <= 0;
		end else begin
			sink_hold <= sink_hold - 1;
		end
	end

	// Pixel checker. Every pixel transfer is matched against the oldest owed write,
	// field by field. Sampling at the clock edge sees the values from before it.
	always @(posedge clk) begin : pixel_check
		pixel_write_t due;
		if (arst_n && pixel_wr.valid && pixel_wr.ready) begin
			if (pixels_due.size() == 0) begin
				$error("pixel write with none expected: address %h value %h last %b",
				       pixel_wr.pixel_address, pixel_wr.pixel_value, pixel_wr.last_pixel);
				error_count++;
			end else begin
				due = pixels_due.pop_front();
				if (pixel_wr.pixel_address !== due.pixel_address) begin
					$error("pixel_address: expected %h, got %h",
					       due.pixel_address, pixel_wr.pixel_address);
					error_count++;
				end
				if (pixel_wr.pixel_value !== due.pixel_value) begin
					$error("pixel_value: expected %h, got %h",
					       due.pixel_value, pixel_wr.pixel_value);
					error_count++;
				end
				if (pixel_wr.last_pixel !== due.last_pixel) begin
					$error("last_pixel: expected %b, got %b",
					       due.last_pixel, pixel_wr.last_pixel);
					error_count++;
				end
			end
		end
	end

	// Glyph sides as the block uses them: anything above the largest side saturates.
	function automatic int unsigned glyph_side(input logic [bgb_pkg::SIDE_CFG_W-1:0] raw);
		return (raw > bgb_pkg::MAX_GLYPH_SIDE_DEF) ? bgb_pkg::MAX_GLYPH_SIDE_DEF : int'(raw);
	endfunction

	// Store position of one glyph row under the current height.
	function automatic int unsigned glyph_row_slot(input logic [bgb_pkg::CODE_W-1:0] code,
	                                               input int unsigned py);
		int unsigned h;
		h = glyph_side(cfg_shadow.glyph_height);
		return ((int'(code) % bgb_pkg::FONT_CHARS_DEF) * h + py) % bgb_pkg::STORE_DEPTH;
	endfunction

	// Works out every pixel write of one draw and appends them to pixels_due.
	// Address arithmetic is done in 32 bits so it wraps exactly as the block's does.
	function automatic void expand_glyph(input glyph_item_t it);
		int unsigned  w;
		int unsigned  h;
		int unsigned  bpp;
		logic [31:0]  colour_mask;
		logic [31:0]  line_addr;
		logic [31:0]  addr;
		logic [7:0]   row_bits;
		pixel_write_t pw;
		w = glyph_side(cfg_shadow.glyph_width);
		h = glyph_side(cfg_shadow.glyph_height);
		if (w == 0 || h == 0) begin
			return;
		end
		// Zero bytes per pixel behaves as one, anything above four as four.
		bpp = int'(cfg_shadow.bytes_per_pixel);
		if (bpp == 0) begin
			bpp = 1;
		end else if (bpp > 4) begin
			bpp = 4;
		end
		case (bpp)
			1:       colour_mask = 32'h0000_00FF;
			2:       colour_mask = 32'h0000_FFFF;
			3:       colour_mask = 32'h00FF_FFFF;
			default: colour_mask = 32'hFFFF_FFFF;
		endcase
		line_addr = cfg_shadow.frame_base
		          + 32'(it.text_row) * h * 32'(cfg_shadow.line_pitch)
		          + 32'(it.text_column) * w * bpp;
		for (int unsigned py = 0; py < h; py++) begin
			row_bits = font_shadow[glyph_row_slot(it.char_code, py)];
			addr     = line_addr;
			for (int unsigned px = 0; px < w; px++) begin
				// The leftmost pixel comes from the most significant font bit.
				pw.pixel_address = addr;
				pw.pixel_value   = (row_bits[bgb_pkg::GLYPH_MSB - px] ?
				                    it.fg_color : it.bg_color) & colour_mask;
				pw.last_pixel    = (py == h - 1) && (px == w - 1);
				pixels_due.push_back(pw);
				addr += bpp;
			end
			line_addr += 32'(cfg_shadow.line_pitch);
		end
	endfunction

	// Keeps the register shadow in step with a completed register write.
	function automatic void shadow_reg(input logic [bgb_pkg::REG_IDX_W-1:0] idx,
	                                   input logic [bgb_pkg::APB_DW-1:0] value);
		case (idx)
			bgb_pkg::REG_FRAME_BASE:
				cfg_shadow.frame_base = value[bgb_pkg::ADDR_W-1:0];
			bgb_pkg::REG_LINE_PITCH:
				cfg_shadow.line_pitch = value[bgb_pkg::PITCH_W-1:0];
			bgb_pkg::REG_BYTES_PER_PIXEL:
				cfg_shadow.bytes_per_pixel = value[bgb_pkg::BPP_W-1:0];
			bgb_pkg::REG_GLYPH_WIDTH:
				cfg_shadow.glyph_width = value[bgb_pkg::SIDE_CFG_W-1:0];
			bgb_pkg::REG_GLYPH_HEIGHT:
				cfg_shadow.glyph_height = value[bgb_pkg::SIDE_CFG_W-1:0];
			default: ;
		endcase
	endfunction

	// An item with every field but mode random; callers then fix the fields that matter.
	function automatic glyph_item_t random_item();
		glyph_item_t it;
		it.mode        = bgb_pkg::MODE_LOAD;
		it.font_index  = bgb_pkg::STORE_AW'($urandom());
		it.font_byte   = bgb_pkg::FONT_BYTE_W'($urandom());
		it.char_code   = bgb_pkg::CODE_W'($urandom());
		it.text_column = bgb_pkg::TEXT_W'($urandom());
		it.text_row    = bgb_pkg::TEXT_W'($urandom());
		it.fg_color    = bgb_pkg::COLOR_W'($urandom());
		it.bg_color    = bgb_pkg::COLOR_W'($urandom());
		return it;
	endfunction

	// Sends one request item and records what it should do once it is accepted.
	// It is always entered at a clock edge, and valid is only lowered when a gap is
	// drawn, so a back-to-back item never sees valid dropped and raised in one step.
	task automatic send_item(input glyph_item_t it);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			glyph_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		glyph_req.valid       <= 1'b1;
		glyph_req.mode        <= it.mode;
		glyph_req.font_index  <= it.font_index;
		glyph_req.font_byte   <= it.font_byte;
		glyph_req.char_code   <= it.char_code;
		glyph_req.text_column <= it.text_column;
		glyph_req.text_row    <= it.text_row;
		glyph_req.fg_color    <= it.fg_color;
		glyph_req.bg_color    <= it.bg_color;
		do @(posedge clk); while (!glyph_req.ready);
		items_sent++;
		if (it.mode == bgb_pkg::MODE_LOAD) begin
			font_shadow[it.font_index] = it.font_byte;
			font_loaded[it.font_index] = 1'b1;
		end else begin
			expand_glyph(it);
		end
	endtask

	task automatic load_font_byte(input int unsigned slot, input logic [7:0] bits);
		glyph_item_t it;
		it            = random_item();
		it.mode       = bgb_pkg::MODE_LOAD;
		it.font_index = bgb_pkg::STORE_AW'(slot);
		it.font_byte  = bits;
		send_item(it);
	endtask

	// Draws one character. Glyph rows that were never loaded are loaded first with
	// random bits, so the block never reads an undefined store entry.
	task automatic draw_char(input logic [bgb_pkg::CODE_W-1:0] code,
	                         input logic [bgb_pkg::TEXT_W-1:0] col,
	                         input logic [bgb_pkg::TEXT_W-1:0] row,
	                         input logic [bgb_pkg::COLOR_W-1:0] fg,
	                         input logic [bgb_pkg::COLOR_W-1:0] bg);
		glyph_item_t it;
		if (glyph_side(cfg_shadow.glyph_width) != 0) begin
			for (int unsigned py = 0; py < glyph_side(cfg_shadow.glyph_height); py++) begin
				if (!font_loaded[glyph_row_slot(code, py)]) begin
					load_font_byte(glyph_row_slot(code, py), 8'($urandom()));
				end
			end
		end
		it             = random_item();
		it.mode        = bgb_pkg::MODE_DRAW;
		it.char_code   = code;
		it.text_column = col;
		it.text_row    = row;
		it.fg_color    = fg;
		it.bg_color    = bg;
		send_item(it);
	endtask

	// Draws the given character at a random cell in random colours.
	task automatic draw_random_char(input logic [bgb_pkg::CODE_W-1:0] code);
		draw_char(code, bgb_pkg::TEXT_W'($urandom()), bgb_pkg::TEXT_W'($urandom()),
		          bgb_pkg::COLOR_W'($urandom()), bgb_pkg::COLOR_W'($urandom()));
	endtask

	// Stops sending and waits until every owed pixel has come out, then lets the
	// block finish any work that produces no pixel, such as a zero-sized draw.
	task automatic drain_pixels();
		glyph_req.valid <= 1'b0;
		while (pixels_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB write: a setup phase and an access phase, then idle with psel low so that a
	// following write raises psel in a later time step.
	task automatic write_reg(input logic [bgb_pkg::REG_IDX_W-1:0] idx,
	                         input logic [bgb_pkg::APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		shadow_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Rewrites all five registers, only once the block has gone idle.
	task automatic set_config(input logic [31:0] base, input logic [15:0] pitch,
	                          input logic [2:0] bpp, input logic [3:0] w,
	                          input logic [3:0] h);
		drain_pixels();
		write_reg(bgb_pkg::REG_FRAME_BASE, base);
		write_reg(bgb_pkg::REG_LINE_PITCH, 32'(pitch));
		write_reg(bgb_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
		write_reg(bgb_pkg::REG_GLYPH_WIDTH, 32'(w));
		write_reg(bgb_pkg::REG_GLYPH_HEIGHT, 32'(h));
	endtask

	// Draws under the reset register values: 8x8 glyphs, four bytes per pixel,
	// pitch 4096, base zero. One glyph has hand-made rows that exercise both
	// ends of every font byte.
	task automatic test_reset_config();
		logic [7:0] pattern [8];
		pattern = '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h3C, 8'hC3};
		for (int unsigned py = 0; py < 8; py++) begin
			load_font_byte(glyph_row_slot(8'h41, py), pattern[py]);
		end
		draw_char(8'h41, 10'd0, 10'd0, 32'hFFFF_FFFF, 32'h0000_0000);
		draw_char(8'h00, 10'd1023, 10'd1023, 32'h0000_0000, 32'hFFFF_FFFF);
		draw_char(8'hFF, 10'd512, 10'd1, 32'h1234_5678, 32'h9ABC_DEF0);
	endtask

	// Every pixel format, including the zero and oversized settings that the block
	// pins to one and four bytes, on a small glyph to keep it quick.
	task automatic test_pixel_formats();
		logic [2:0] formats [6];
		formats = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7};
		foreach (formats[i]) begin
			set_config(32'h0001_0000, 16'd640, formats[i], 4'd3, 4'd2);
			draw_char(8'h41, 10'd5, 10'd3, 32'hA5C3_7E81, 32'h5A3C_817E);
		end
	endtask

	// Glyph sizes: the smallest, the largest, sides above the largest (saturated),
	// and a zero width or a zero height, which must draw nothing.
	task automatic test_glyph_sizes();
		set_config(32'h0, 16'd320, 3'd2, 4'd1, 4'd1);
		draw_char(8'h7F, 10'd1023, 10'd0, 32'hFFFF_0001, 32'h0000_FFFE);
		set_config(32'h0, 16'd320, 3'd1, 4'd15, 4'd9);
		draw_char(8'h80, 10'd7, 10'd7, 32'h0000_00FF, 32'h0000_0001);
		set_config(32'h0, 16'd320, 3'd4, 4'd0, 4'd8);
		draw_char(8'h41, 10'd1, 10'd1, 32'h1, 32'h2);
		set_config(32'h0, 16'd320, 3'd4, 4'd8, 4'd0);
		draw_char(8'h41, 10'd1, 10'd1, 32'h1, 32'h2);
		set_config(32'h0, 16'd320, 3'd3, 4'd5, 4'd7);
		draw_char(8'hC0, 10'd100, 10'd200, 32'hDEAD_BEEF, 32'hCAFE_F00D);
	endtask

	// Address generation: a zero pitch that stacks every glyph row on one line, the
	// widest pitch, and a frame base near the top of memory so that addresses wrap.
	task automatic test_addressing();
		set_config(32'h0000_8000, 16'd0, 3'd4, 4'd4, 4'd4);
		draw_char(8'h41, 10'd9, 10'd9, 32'hF0F0_F0F0, 32'h0F0F_0F0F);
		set_config(32'h0000_0000, 16'd65535, 3'd4, 4'd8, 4'd8);
		draw_char(8'h41, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'h0);
		set_config(32'hFFFF_FFFF, 16'd65535, 3'd4, 4'd8, 4'd8);
		draw_char(8'hFF, 10'd1023, 10'd1023, 32'h8000_0001, 32'h7FFF_FFFE);
		set_config(32'hFFFF_FFF0, 16'd1, 3'd3, 4'd6, 4'd3);
		draw_char(8'h20, 10'd0, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	// Random traffic in phases that share out what is left of the item budget.
	// Each phase picks a fresh register setting, mostly in range but now and then
	// zero or oversized, and a small pool of character codes, and then sends mostly
	// draws with random content plus random font loads as noise. Some phases run one
	// side or both with no idle cycles, and one phase pauses mid-way until all is
	// drained.
	task automatic test_random_traffic();
		logic [15:0]                pitch;
		logic [3:0]                 w;
		logic [3:0]                 h;
		logic [bgb_pkg::CODE_W-1:0] code_base;
		int                         start_count;
		int                         phase_end;
		int                         n;
		start_count = items_sent;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       pitch = 16'd0;
				1:       pitch = 16'd65535;
				default: pitch = 16'($urandom());
			endcase
			w = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			                                : 4'($urandom_range(1, 8));
			h = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			                                : 4'($urandom_range(1, 8));
			set_config($urandom(), pitch, 3'($urandom_range(0, 7)), w, h);
			sender_calm = ($urandom_range(0, 3) == 0);
			sink_calm   = ($urandom_range(0, 3) == 0);
			code_base   = bgb_pkg::CODE_W'($urandom());
			phase_end   = start_count
			            + (ITEM_TARGET - start_count) * (phase + 1) / RANDOM_PHASES;
			n = 0;
			while (items_sent < phase_end) begin
				if (phase == PAUSE_PHASE && n == 4) begin
					drain_pixels();
				end
				if ($urandom_range(0, 9) < 7) begin
					draw_random_char(code_base +
					                 bgb_pkg::CODE_W'($urandom_range(0, CODE_POOL - 1)));
				end else begin
					load_font_byte($urandom_range(0, bgb_pkg::STORE_DEPTH - 1),
					               8'($urandom()));
				end
				n++;
			end
		end
		sender_calm = 1'b0;
		sink_calm   = 1'b0;
	endtask

	initial begin
		cfg_shadow.frame_base      = 32'h0;
		cfg_shadow.line_pitch      = 16'd4096;
		cfg_shadow.bytes_per_pixel = 3'd4;
		cfg_shadow.glyph_width     = 4'd8;
		cfg_shadow.glyph_height    = 4'd8;
		foreach (font_loaded[i]) begin
			font_loaded[i] = 1'b0;
			font_shadow[i] = '0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_pixel_formats();
		test_glyph_sizes();
		test_addressing();
		test_random_traffic();

		// Let the last glyph finish and watch for stray pixels after it.
		drain_pixels();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
